### src/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types, widths and constants for the HSL to RGB converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hslrgb_pkg;

  // default number of fraction bits in the internal fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // input and output field widths
  localparam int HUE_W = 13;
  localparam int PCT_W = 11;
  localparam int CH_W  = 8;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // input ranges
  localparam int HUE_MAX      = 5744;
  localparam int PCT_MAX      = 1600;
  localparam int SEXTANT_SPAN = 960;

  // 1600 = 64 * 25 and 960 = 64 * 15: the power of two becomes a shift
  localparam int POW2_SHIFT = 6;
  localparam int PCT_DIV    = 25;
  localparam int SPAN_DIV   = 15;

  // reciprocal multiply for the small divisors (exact over the input range)
  localparam int RECIP_PCT   = 1311;
  localparam int RECIP_SPAN  = 2185;
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_PW    = 22;

  // quotient and remainder widths of the split divides
  localparam int PCT_Q_W  = 7;
  localparam int PCT_R_W  = 5;
  localparam int HREM_W   = 10;
  localparam int SPAN_Q_W = 6;
  localparam int SPAN_R_W = 4;

  // hue sextants, red through magenta
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

endpackage

### src/hslrgb_prep.sv
// ----------------------------------------------------------------------------
// hslrgb_prep
// Input clamp, fixed-point scaling of lightness, saturation and hue
// fraction, and the lightness * saturation product. Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hslrgb_prep #(
  parameter int F = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // upstream
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [hslrgb_pkg::HUE_W-1:0] up_hue,
  input  logic [hslrgb_pkg::PCT_W-1:0] up_sat,
  input  logic [hslrgb_pkg::PCT_W-1:0] up_lig,
  // downstream
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [F:0]                  dn_l,
  output logic [F:0]                  dn_s,
  output logic [F:0]                  dn_p,
  output logic                        dn_lo,
  output hslrgb_pkg::sextant_t        dn_sext,
  output logic [F-1:0]                dn_fract
);
  import hslrgb_pkg::*;

  localparam int FW = F - POW2_SHIFT;
  localparam int PW = 2 * F + 2;

  typedef logic [PCT_DIV-1:0][FW-1:0]  tab_pct_t;
  typedef logic [SPAN_DIV-1:0][FW-1:0] tab_span_t;

  // remainder tables: floor(r * 2^FW / divisor)
  function automatic tab_pct_t mk_tab_pct();
    tab_pct_t t;
    for (int i = 0; i < PCT_DIV; i++) t[i] = FW'((i << FW) / PCT_DIV);
    return t;
  endfunction

  function automatic tab_span_t mk_tab_span();
    tab_span_t t;
    for (int i = 0; i < SPAN_DIV; i++) t[i] = FW'((i << FW) / SPAN_DIV);
    return t;
  endfunction

  localparam tab_pct_t  TAB_PCT  = mk_tab_pct();
  localparam tab_span_t TAB_SPAN = mk_tab_span();

  // stage valid bits and enables
  logic [2:0] vld_r;
  logic [2:0] en;

  assign en[2]    = !vld_r[2] || dn_ready;
  assign en[1]    = !vld_r[1] || en[2];
  assign en[0]    = !vld_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // stage 0: clamp, coarse quotients, sextant split
  logic [HUE_W-1:0]    hue_c;
  logic [PCT_W-1:0]    sat_c;
  logic [PCT_W-1:0]    lig_c;
  logic [RECIP_PW-1:0] lq_prod;
  logic [RECIP_PW-1:0] sq_prod;
  logic [HUE_W-1:0]    hue_base;
  logic [HUE_W-1:0]    hue_diff;

  logic [PCT_W-1:0]   lig_nxt, sat_nxt;
  logic [PCT_Q_W-1:0] lq_nxt, sq_nxt;
  logic               lo_nxt;
  sextant_t           sext0_nxt;
  logic [HREM_W-1:0]  hrem_nxt;

  logic [PCT_W-1:0]   lig_r, sat_r;
  logic [PCT_Q_W-1:0] lq_r, sq_r;
  logic               lo0_r;
  sextant_t           sext0_r;
  logic [HREM_W-1:0]  hrem0_r;

  always_comb begin
    hue_c = (up_hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : up_hue;
    sat_c = (up_sat > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : up_sat;
    lig_c = (up_lig > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : up_lig;

    lq_prod = RECIP_PW'(lig_c) * RECIP_PW'(RECIP_PCT);
    sq_prod = RECIP_PW'(sat_c) * RECIP_PW'(RECIP_PCT);

    // sextant by compare against the span boundaries
    if (hue_c >= HUE_W'(5 * SEXTANT_SPAN)) begin
      sext0_nxt = SEXT_MAG_RED;
      hue_base  = HUE_W'(5 * SEXTANT_SPAN);
    end else if (hue_c >= HUE_W'(4 * SEXTANT_SPAN)) begin
      sext0_nxt = SEXT_BLU_MAG;
      hue_base  = HUE_W'(4 * SEXTANT_SPAN);
    end else if (hue_c >= HUE_W'(3 * SEXTANT_SPAN)) begin
      sext0_nxt = SEXT_CYN_BLU;
      hue_base  = HUE_W'(3 * SEXTANT_SPAN);
    end else if (hue_c >= HUE_W'(2 * SEXTANT_SPAN)) begin
      sext0_nxt = SEXT_GRN_CYN;
      hue_base  = HUE_W'(2 * SEXTANT_SPAN);
    end else if (hue_c >= HUE_W'(SEXTANT_SPAN)) begin
      sext0_nxt = SEXT_YEL_GRN;
      hue_base  = HUE_W'(SEXTANT_SPAN);
    end else begin
      sext0_nxt = SEXT_RED_YEL;
      hue_base  = '0;
    end
    hue_diff = hue_c - hue_base;

    lig_nxt  = lig_c;
    sat_nxt  = sat_c;
    lq_nxt   = lq_prod[RECIP_SHIFT +: PCT_Q_W];
    sq_nxt   = sq_prod[RECIP_SHIFT +: PCT_Q_W];
    lo_nxt   = (lig_c <= PCT_W'(PCT_MAX / 2));
    hrem_nxt = hue_diff[HREM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lig_r   <= lig_nxt;
      sat_r   <= sat_nxt;
      lq_r    <= lq_nxt;
      sq_r    <= sq_nxt;
      lo0_r   <= lo_nxt;
      sext0_r <= sext0_nxt;
      hrem0_r <= hrem_nxt;
    end
  end

  // stage 1: remainders and table lookup give L and S; coarse hue quotient
  logic [PCT_W-1:0]    lmul, smul, ldiff, sdiff;
  logic [RECIP_PW-1:0] hq_prod;
  logic [F:0]          l1_nxt, s1_nxt;
  logic [SPAN_Q_W-1:0] hq_nxt;

  logic [F:0]          l1_r, s1_r;
  logic                lo1_r;
  sextant_t            sext1_r;
  logic [HREM_W-1:0]   hrem1_r;
  logic [SPAN_Q_W-1:0] hq_r;

  always_comb begin
    lmul    = PCT_W'(lq_r) * PCT_W'(PCT_DIV);
    smul    = PCT_W'(sq_r) * PCT_W'(PCT_DIV);
    ldiff   = lig_r - lmul;
    sdiff   = sat_r - smul;
    l1_nxt  = {lq_r, TAB_PCT[ldiff[PCT_R_W-1:0]]};
    s1_nxt  = {sq_r, TAB_PCT[sdiff[PCT_R_W-1:0]]};
    hq_prod = RECIP_PW'(hrem0_r) * RECIP_PW'(RECIP_SPAN);
    hq_nxt  = hq_prod[RECIP_SHIFT +: SPAN_Q_W];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l1_r    <= l1_nxt;
      s1_r    <= s1_nxt;
      lo1_r   <= lo0_r;
      sext1_r <= sext0_r;
      hrem1_r <= hrem0_r;
      hq_r    <= hq_nxt;
    end
  end

  // stage 2: L * S product and hue fraction
  logic [PW-1:0]     ls_prod;
  logic [HREM_W-1:0] hmul, hdiff;
  logic [F:0]        p_nxt;
  logic [F-1:0]      fract_nxt;

  logic [F:0]        l2_r, s2_r, p2_r;
  logic              lo2_r;
  sextant_t          sext2_r;
  logic [F-1:0]      fract2_r;

  always_comb begin
    ls_prod   = PW'(l1_r) * PW'(s1_r);
    p_nxt     = ls_prod[2*F:F];
    hmul      = HREM_W'(hq_r) * HREM_W'(SPAN_DIV);
    hdiff     = hrem1_r - hmul;
    fract_nxt = {hq_r, TAB_SPAN[hdiff[SPAN_R_W-1:0]]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l2_r     <= l1_r;
      s2_r     <= s1_r;
      p2_r     <= p_nxt;
      lo2_r    <= lo1_r;
      sext2_r  <= sext1_r;
      fract2_r <= fract_nxt;
    end
  end

  assign dn_l     = l2_r;
  assign dn_s     = s2_r;
  assign dn_p     = p2_r;
  assign dn_lo    = lo2_r;
  assign dn_sext  = sext2_r;
  assign dn_fract = fract2_r;

endmodule

### src/hslrgb_blend.sv
// ----------------------------------------------------------------------------
// hslrgb_blend
// Chroma top v, bottom m and the blend term (v - m) * fract.
// Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hslrgb_blend #(
  parameter int F = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // upstream
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [F:0]           up_l,
  input  logic [F:0]           up_s,
  input  logic [F:0]           up_p,
  input  logic                 up_lo,
  input  hslrgb_pkg::sextant_t up_sext,
  input  logic [F-1:0]         up_fract,
  // downstream
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [F:0]           dn_l,
  output logic [F:0]           dn_v,
  output logic [F:0]           dn_m,
  output logic [F:0]           dn_vsf,
  output hslrgb_pkg::sextant_t dn_sext
);
  import hslrgb_pkg::*;

  localparam int VW = F + 2;
  localparam int MW = 2 * F + 1;
  localparam logic [VW-1:0] ONE = VW'(1) << F;

  // stage valid bits and enables
  logic [2:0] vld_r;
  logic [2:0] en;

  assign en[2]    = !vld_r[2] || dn_ready;
  assign en[1]    = !vld_r[1] || en[2];
  assign en[0]    = !vld_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // stage 0: chroma top, clamped to 1.0
  logic [VW-1:0] lp_sum, ls_sum, v_raw;
  logic [F:0]    v_nxt;

  logic [F:0]    l0_r, v0_r;
  sextant_t      sext0_r;
  logic [F-1:0]  fract0_r;

  always_comb begin
    lp_sum = VW'(up_l) + VW'(up_p);
    ls_sum = VW'(up_l) + VW'(up_s);
    if (up_lo) begin
      v_raw = lp_sum;
    end else if (ls_sum > VW'(up_p)) begin
      v_raw = ls_sum - VW'(up_p);
    end else begin
      v_raw = '0;
    end
    v_nxt = (v_raw > ONE) ? ONE[F:0] : v_raw[F:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l0_r     <= up_l;
      v0_r     <= v_nxt;
      sext0_r  <= up_sext;
      fract0_r <= up_fract;
    end
  end

  // stage 1: bottom m = 2L - v, kept within 0..v
  logic [VW-1:0] l_dbl, m_raw;
  logic [F:0]    m_nxt;

  logic [F:0]    l1_r, v1_r, m1_r;
  sextant_t      sext1_r;
  logic [F-1:0]  fract1_r;

  always_comb begin
    l_dbl = {l0_r, 1'b0};
    m_raw = (l_dbl > VW'(v0_r)) ? (l_dbl - VW'(v0_r)) : '0;
    m_nxt = (m_raw > VW'(v0_r)) ? v0_r : m_raw[F:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l1_r     <= l0_r;
      v1_r     <= v0_r;
      m1_r     <= m_nxt;
      sext1_r  <= sext0_r;
      fract1_r <= fract0_r;
    end
  end

  // stage 2: blend term (v - m) * fract
  logic [F:0]    vm_diff;
  logic [MW-1:0] vsf_prod;

  logic [F:0]    l2_r, v2_r, m2_r, vsf2_r;
  sextant_t      sext2_r;

  always_comb begin
    vm_diff  = v1_r - m1_r;
    vsf_prod = MW'(vm_diff) * MW'(fract1_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l2_r    <= l1_r;
      v2_r    <= v1_r;
      m2_r    <= m1_r;
      vsf2_r  <= vsf_prod[2*F:F];
      sext2_r <= sext1_r;
    end
  end

  assign dn_l    = l2_r;
  assign dn_v    = v2_r;
  assign dn_m    = m2_r;
  assign dn_vsf  = vsf2_r;
  assign dn_sext = sext2_r;

endmodule

### src/hslrgb_out.sv
// ----------------------------------------------------------------------------
// hslrgb_out
// Channel selection by sextant and scaling to 8-bit channels.
// Two register stages, the last one is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hslrgb_out #(
  parameter int F = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // upstream
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [F:0]                 up_l,
  input  logic [F:0]                 up_v,
  input  logic [F:0]                 up_m,
  input  logic [F:0]                 up_vsf,
  input  hslrgb_pkg::sextant_t       up_sext,
  // downstream
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [hslrgb_pkg::CH_W-1:0] dn_red,
  output logic [hslrgb_pkg::CH_W-1:0] dn_green,
  output logic [hslrgb_pkg::CH_W-1:0] dn_blue
);
  import hslrgb_pkg::*;

  localparam int SW = F + 1 + CH_W;

  // stage valid bits and enables
  logic [1:0] vld_r;
  logic [1:0] en;

  assign en[1]    = !vld_r[1] || dn_ready;
  assign en[0]    = !vld_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = vld_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  // stage 0: middle values and channel routing
  logic [F:0] mid1, mid2;
  logic [F:0] r_nxt, g_nxt, b_nxt;
  logic [F:0] r_r, g_r, b_r;

  always_comb begin
    mid1 = up_m + up_vsf;
    mid2 = up_v - up_vsf;
    r_nxt = up_l;
    g_nxt = up_l;
    b_nxt = up_l;
    // zero chroma top leaves all channels at lightness
    if (up_v != '0) begin
      case (up_sext)
        SEXT_RED_YEL: begin r_nxt = up_v; g_nxt = mid1; b_nxt = up_m; end
        SEXT_YEL_GRN: begin r_nxt = mid2; g_nxt = up_v; b_nxt = up_m; end
        SEXT_GRN_CYN: begin r_nxt = up_m; g_nxt = up_v; b_nxt = mid1; end
        SEXT_CYN_BLU: begin r_nxt = up_m; g_nxt = mid2; b_nxt = up_v; end
        SEXT_BLU_MAG: begin r_nxt = mid1; g_nxt = up_m; b_nxt = up_v; end
        default:      begin r_nxt = up_v; g_nxt = up_m; b_nxt = mid2; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r <= r_nxt;
      g_r <= g_nxt;
      b_r <= b_nxt;
    end
  end

  // stage 1: channel * 255 by shift and subtract, truncated and limited
  function automatic logic [CH_W-1:0] to_byte(input logic [F:0] c);
    logic [SW-1:0]   scaled;
    logic [CH_W:0]   whole;
    scaled = {c, CH_W'(0)} - SW'(c);
    whole  = scaled[SW-1:F];
    return whole[CH_W] ? {CH_W{1'b1}} : whole[CH_W-1:0];
  endfunction

  logic [CH_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      red_r   <= to_byte(r_r);
      green_r <= to_byte(g_r);
      blue_r  <= to_byte(b_r);
    end
  end

  assign dn_red   = red_r;
  assign dn_green = green_r;
  assign dn_blue  = blue_r;

endmodule

### src/hsl_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// Pipeline: 8 register stages. Throughput: one color per clock unless
// out_tready stalls; a full stage holds while the next cannot take its
// item, so empty stages keep filling while the output is stalled.
// Reset: synchronous active-low rst_n clears all stage valid bits; no state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_to_rgb_converter_unit #(
  parameter int INTERNAL_FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hslrgb_pkg::IN_TDATA_W-1:0]  in_tdata,  // hue, saturation, lightness
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hslrgb_pkg::OUT_TDATA_W-1:0] out_tdata  // red, green, blue
);
  import hslrgb_pkg::*;

  localparam int F = INTERNAL_FRAC_BITS;

  // unpack input fields
  logic [HUE_W-1:0] in_hue;
  logic [PCT_W-1:0] in_sat;
  logic [PCT_W-1:0] in_lig;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: PCT_W];
  assign in_lig = in_tdata[HUE_W+PCT_W +: PCT_W];

  // scaling stages
  logic         pb_valid, pb_ready;
  logic [F:0]   pb_l, pb_s, pb_p;
  logic         pb_lo;
  sextant_t     pb_sext;
  logic [F-1:0] pb_fract;

  hslrgb_prep #(.F(F)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_hue   (in_hue),
    .up_sat   (in_sat),
    .up_lig   (in_lig),
    .dn_valid (pb_valid),
    .dn_ready (pb_ready),
    .dn_l     (pb_l),
    .dn_s     (pb_s),
    .dn_p     (pb_p),
    .dn_lo    (pb_lo),
    .dn_sext  (pb_sext),
    .dn_fract (pb_fract)
  );

  // chroma and blend stages
  logic       bo_valid, bo_ready;
  logic [F:0] bo_l, bo_v, bo_m, bo_vsf;
  sextant_t   bo_sext;

  hslrgb_blend #(.F(F)) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pb_valid),
    .up_ready (pb_ready),
    .up_l     (pb_l),
    .up_s     (pb_s),
    .up_p     (pb_p),
    .up_lo    (pb_lo),
    .up_sext  (pb_sext),
    .up_fract (pb_fract),
    .dn_valid (bo_valid),
    .dn_ready (bo_ready),
    .dn_l     (bo_l),
    .dn_v     (bo_v),
    .dn_m     (bo_m),
    .dn_vsf   (bo_vsf),
    .dn_sext  (bo_sext)
  );

  // channel routing and byte scaling
  logic [CH_W-1:0] red, green, blue;

  hslrgb_out #(.F(F)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (bo_valid),
    .up_ready (bo_ready),
    .up_l     (bo_l),
    .up_v     (bo_v),
    .up_m     (bo_m),
    .up_vsf   (bo_vsf),
    .up_sext  (bo_sext),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_red   (red),
    .dn_green (green),
    .dn_blue  (blue)
  );

  // pack output fields
  assign out_tdata = {blue, green, red};

endmodule

### tb/sv/hsl_to_rgb_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit_tb
// Self-checking bench for the HSL to RGB converter. A queue of colors,
// directed corners first and then random ones, feeds a stream driver.
// Each input transfer is run through a fixed-point color predictor, and
// every output transfer is compared channel by channel with the oldest
// predicted color. Random gaps and stalls are applied on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_to_rgb_converter_unit_tb;
  import hslrgb_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int N_RANDOM   = 650;
  localparam int DRAIN_CYC  = 16;

  typedef struct packed {
    logic [PCT_W-1:0] lig;
    logic [PCT_W-1:0] sat;
    logic [HUE_W-1:0] hue;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  hsl_t pending_colors[$];
  rgb_t expected_rgb[$];
  int   n_colors = 0;
  int   n_accepted = 0;
  int   n_results = 0;
  int   n_errors = 0;
  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   in_idle_pct = 30;
  int   out_stall = 0;
  int   out_idle_pct = 30;

  hsl_to_rgb_converter_unit #(
    .INTERNAL_FRAC_BITS(FRAC)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // fixed-point hsl to rgb prediction
  function automatic rgb_t hsl_to_rgb_predict(hsl_t c);
    logic [63:0] one, hue, sat, lig, l_fx, s_fx, prod, v, m, fract, vsf;
    logic [63:0] mid1, mid2, r, g, b;
    sextant_t    sext;
    rgb_t        res;
    one = 64'd1 << FRAC;
    hue = (c.hue > HUE_MAX) ? 64'(HUE_MAX) : 64'(c.hue);
    sat = (c.sat > PCT_MAX) ? 64'(PCT_MAX) : 64'(c.sat);
    lig = (c.lig > PCT_MAX) ? 64'(PCT_MAX) : 64'(c.lig);
    l_fx = (lig << FRAC) / PCT_MAX;
    s_fx = (sat << FRAC) / PCT_MAX;
    prod = (l_fx * s_fx) >> FRAC;
    if (2 * lig <= PCT_MAX) begin
      v = l_fx + prod;
    end else begin
      v = (l_fx + s_fx > prod) ? (l_fx + s_fx - prod) : 64'd0;
    end
    if (v > one) v = one;
    r = l_fx;
    g = l_fx;
    b = l_fx;
    if (v > 0) begin
      sext  = sextant_t'(hue / SEXTANT_SPAN);
      fract = ((hue % SEXTANT_SPAN) << FRAC) / SEXTANT_SPAN;
      m     = (2 * l_fx > v) ? (2 * l_fx - v) : 64'd0;
      if (m > v) m = v;
      vsf  = ((v - m) * fract) >> FRAC;
      mid1 = m + vsf;
      mid2 = v - vsf;
      case (sext)
        SEXT_RED_YEL: begin r = v;    g = mid1; b = m;    end
        SEXT_YEL_GRN: begin r = mid2; g = v;    b = m;    end
        SEXT_GRN_CYN: begin r = m;    g = v;    b = mid1; end
        SEXT_CYN_BLU: begin r = m;    g = mid2; b = v;    end
        SEXT_BLU_MAG: begin r = mid1; g = m;    b = v;    end
        default:      begin r = v;    g = m;    b = mid2; end
      endcase
    end
    r = (r * 255) >> FRAC;
    g = (g * 255) >> FRAC;
    b = (b * 255) >> FRAC;
    res.red   = (r > 255) ? 8'd255 : r[CH_W-1:0];
    res.green = (g > 255) ? 8'd255 : g[CH_W-1:0];
    res.blue  = (b > 255) ? 8'd255 : b[CH_W-1:0];
    return res;
  endfunction

  // idle length: none with probability 100 - pct percent, else mostly short, a few long
  function automatic int pick_idle(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_color(int hue, int sat, int lig);
    hsl_t c;
    c.hue = HUE_W'(hue);
    c.sat = PCT_W'(sat);
    c.lig = PCT_W'(lig);
    pending_colors.push_back(c);
    n_colors++;
  endtask

  // input stream driver
  always @(negedge clk) begin
    hsl_t c;
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold the current transfer
      end else if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_colors.size() != 0) begin
        c = pending_colors.pop_front();
        in_tdata  <= {{(IN_TDATA_W - $bits(hsl_t)){1'b0}}, c};
        in_tvalid <= 1'b1;
        in_gap = pick_idle(in_idle_pct);
        if ($urandom_range(0, 63) == 0) in_idle_pct = $urandom_range(0, 2) * 35;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready stalls
  always @(negedge clk) begin
    int g;
    if (rst_n) begin
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        g = pick_idle(out_idle_pct);
        out_tready <= (g == 0);
        out_stall = (g > 0) ? g - 1 : 0;
        if ($urandom_range(0, 63) == 0) out_idle_pct = $urandom_range(0, 2) * 35;
      end
    end
  end

  // input transfer capture and prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_rgb.push_back(hsl_to_rgb_predict(hsl_t'(in_tdata[$bits(hsl_t)-1:0])));
        n_accepted++;
      end
    end
  end

  // output transfer check
  always @(posedge clk) begin
    rgb_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rgb_t'(out_tdata[$bits(rgb_t)-1:0]);
      n_results++;
      if (expected_rgb.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected color r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
        want = expected_rgb.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("color %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     n_results - 1, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sel;
    // black, white, saturated and out-of-range corners
    add_color(0, 0, 0);
    add_color(0, PCT_MAX, PCT_MAX / 2);
    add_color(0, PCT_MAX, PCT_MAX);
    add_color(0, 0, PCT_MAX);
    add_color(8191, 2047, 2047);
    add_color(3000, 2047, 0);
    // sextant edges
    add_color(959, PCT_MAX, PCT_MAX / 2);
    add_color(960, PCT_MAX, PCT_MAX / 2);
    add_color(1919, PCT_MAX, PCT_MAX / 2);
    add_color(1920, PCT_MAX, PCT_MAX / 2);
    add_color(2880, PCT_MAX, PCT_MAX / 2);
    add_color(3840, PCT_MAX, PCT_MAX / 2);
    add_color(4800, PCT_MAX, PCT_MAX / 2);
    add_color(HUE_MAX, PCT_MAX, PCT_MAX / 2);
    add_color(HUE_MAX + 1, PCT_MAX, PCT_MAX / 2);
    // dark and light halves, lightness just over the midpoint, out-of-range fields
    add_color(2400, PCT_MAX, 400);
    add_color(2400, PCT_MAX, 1200);
    add_color(2400, 800, PCT_MAX / 2 + 1);
    add_color(4000, 1200, 1);
    add_color(300, 1, PCT_MAX - 1);
    add_color(5000, PCT_MAX + 1, PCT_MAX + 1);
    add_color(7000, 1700, 900);
    // random colors, mostly in range
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 9);
      add_color((sel == 0) ? $urandom_range(0, 8191) : $urandom_range(0, HUE_MAX),
                (sel == 1) ? $urandom_range(0, 2047) : $urandom_range(0, PCT_MAX),
                (sel == 2) ? $urandom_range(0, 2047) : $urandom_range(0, PCT_MAX));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_colors || expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
src/hslrgb_pkg.sv
src/hslrgb_prep.sv
src/hslrgb_blend.sv
src/hslrgb_out.sv
src/hsl_to_rgb_converter_unit.sv
tb/sv/hsl_to_rgb_converter_unit_tb.sv
